// ----- rtl/lav_pkg.sv -----
// Shared constants and types for the look-at view matrix block.
`timescale 1ns / 1ps

package lav_pkg;

    localparam int AXIS_FRAC_BITS_DEF = 16;   // fraction bits of a unit axis
    localparam int COORD_W            = 32;   // width of a coordinate field
    localparam int VEC_W              = 64;   // wide vector component width

    typedef enum logic [1:0] {
        ROW_X = 2'd0,
        ROW_Y = 2'd1,
        ROW_Z = 2'd2
    } row_t;

endpackage

// ----- rtl/lav_norm.sv -----
// Pipelined normalizer: scales a wide 3-vector to a unit axis, one item per cycle while en is high.
`timescale 1ns / 1ps

module lav_norm #(
    parameter int AXIS_FRAC_BITS = lav_pkg::AXIS_FRAC_BITS_DEF,
    parameter int SB_W           = 1
) (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic                                    en,
    input  logic                                    in_valid,
    input  logic [2:0][lav_pkg::VEC_W-1:0]          in_vec,
    input  logic [SB_W-1:0]                         in_sb,
    output logic                                    out_valid,
    output logic [2:0][AXIS_FRAC_BITS+1:0]          out_axis,
    output logic                                    out_ok,
    output logic [SB_W-1:0]                         out_sb
);

    localparam int AW    = AXIS_FRAC_BITS + 2;
    localparam int QW    = AXIS_FRAC_BITS + 1;
    localparam int NW    = AXIS_FRAC_BITS + 32;
    localparam int NSQ   = 32;
    localparam int SQ0   = 5;
    localparam int DV0   = SQ0 + NSQ + 1;
    localparam int DEPTH = DV0 + QW;

    typedef struct packed {
        logic [SB_W-1:0]   sb;
        logic              zero;
        logic [2:0]        neg;
        logic [5:0]        p;
        logic [2:0][63:0]  m;
        logic [2:0][61:0]  sq;
        logic [63:0]       s;
        logic [63:0]       r;
        logic [2:0][31:0]  rem;
        logic [2:0][QW-1:0] q;
    } st_t;

    st_t              pipe_reg [DEPTH];
    st_t              pipe_next [DEPTH];
    logic [DEPTH-1:0] vld_reg;
    logic             out_valid_reg;
    logic [2:0][AW-1:0] axis_reg;
    logic             ok_reg;
    logic [SB_W-1:0]  sb_reg;

    function automatic logic [5:0] msb64(input logic [63:0] v);
        logic [5:0] pos;
        pos = '0;
        for (int b = 0; b < 64; b++) begin
            if (v[b]) begin
                pos = 6'(b);
            end
        end
        return pos;
    endfunction

    genvar j;
    generate
        for (j = 0; j < DEPTH; j++) begin : g_stage
            if (j == 0) begin : g_mag
                always_comb begin
                    pipe_next[j]    = '0;
                    pipe_next[j].sb = in_sb;
                    for (int i = 0; i < 3; i++) begin
                        pipe_next[j].neg[i] = in_vec[i][63];
                        pipe_next[j].m[i]   = in_vec[i][63] ? (64'd0 - in_vec[i]) : in_vec[i];
                    end
                end
            end else if (j == 1) begin : g_lzc
                always_comb begin
                    logic [63:0] orv;
                    orv            = pipe_reg[j-1].m[0] | pipe_reg[j-1].m[1] | pipe_reg[j-1].m[2];
                    pipe_next[j]      = pipe_reg[j-1];
                    pipe_next[j].p    = msb64(orv);
                    pipe_next[j].zero = (orv == 64'd0);
                end
            end else if (j == 2) begin : g_shift
                // bring the largest magnitude into [2^30, 2^31)
                always_comb begin
                    logic [63:0] sh;
                    pipe_next[j] = pipe_reg[j-1];
                    for (int i = 0; i < 3; i++) begin
                        if (pipe_reg[j-1].p >= 6'd31) begin
                            sh = pipe_reg[j-1].m[i] >> (pipe_reg[j-1].p - 6'd30);
                        end else begin
                            sh = pipe_reg[j-1].m[i] << (6'd30 - pipe_reg[j-1].p);
                        end
                        pipe_next[j].m[i] = {33'd0, sh[30:0]};
                    end
                end
            end else if (j == 3) begin : g_sq
                always_comb begin
                    pipe_next[j] = pipe_reg[j-1];
                    for (int i = 0; i < 3; i++) begin
                        pipe_next[j].sq[i] = pipe_reg[j-1].m[i][30:0] * pipe_reg[j-1].m[i][30:0];
                    end
                end
            end else if (j == 4) begin : g_sum
                always_comb begin
                    pipe_next[j]   = pipe_reg[j-1];
                    pipe_next[j].s = 64'(pipe_reg[j-1].sq[0]) + 64'(pipe_reg[j-1].sq[1])
                                   + 64'(pipe_reg[j-1].sq[2]);
                    pipe_next[j].r = '0;
                end
            end else if (j < SQ0 + NSQ) begin : g_sqrt
                // one result bit per stage
                localparam logic [63:0] BITV = 64'd1 << (62 - 2 * (j - SQ0));
                always_comb begin
                    logic [64:0] t;
                    t            = {1'b0, pipe_reg[j-1].r} + {1'b0, BITV};
                    pipe_next[j] = pipe_reg[j-1];
                    if ({1'b0, pipe_reg[j-1].s} >= t) begin
                        pipe_next[j].s = pipe_reg[j-1].s - t[63:0];
                        pipe_next[j].r = (pipe_reg[j-1].r >> 1) + BITV;
                    end else begin
                        pipe_next[j].r = pipe_reg[j-1].r >> 1;
                    end
                end
            end else if (j == SQ0 + NSQ) begin : g_num
                // rounded numerator (m << frac) + n/2, top bits seed the remainder
                always_comb begin
                    logic [NW-1:0] num;
                    pipe_next[j] = pipe_reg[j-1];
                    for (int i = 0; i < 3; i++) begin
                        num = (NW'(pipe_reg[j-1].m[i][30:0]) << AXIS_FRAC_BITS)
                            + NW'(pipe_reg[j-1].r[31:1]);
                        pipe_next[j].m[i]   = 64'(num);
                        pipe_next[j].rem[i] = 32'(num >> QW);
                        pipe_next[j].q[i]   = '0;
                    end
                end
            end else begin : g_div
                // one quotient bit per stage, restoring
                localparam int BI = QW - 1 - (j - DV0);
                always_comb begin
                    logic [32:0] trial;
                    pipe_next[j] = pipe_reg[j-1];
                    for (int i = 0; i < 3; i++) begin
                        trial = {pipe_reg[j-1].rem[i], pipe_reg[j-1].m[i][BI]};
                        if (trial >= {1'b0, pipe_reg[j-1].r[31:0]}) begin
                            pipe_next[j].rem[i]   = 32'(trial - {1'b0, pipe_reg[j-1].r[31:0]});
                            pipe_next[j].q[i][BI] = 1'b1;
                        end else begin
                            pipe_next[j].rem[i] = trial[31:0];
                        end
                    end
                end
            end
        end
    endgenerate

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else if (en) begin
            vld_reg       <= {vld_reg[DEPTH-2:0], in_valid};
            out_valid_reg <= vld_reg[DEPTH-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < DEPTH; k++) begin
                pipe_reg[k] <= pipe_next[k];
            end
            for (int i = 0; i < 3; i++) begin
                axis_reg[i] <= pipe_reg[DEPTH-1].neg[i]
                             ? AW'(0) - {1'b0, pipe_reg[DEPTH-1].q[i]}
                             : {1'b0, pipe_reg[DEPTH-1].q[i]};
            end
            ok_reg <= !pipe_reg[DEPTH-1].zero;
            sb_reg <= pipe_reg[DEPTH-1].sb;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_axis  = axis_reg;
    assign out_ok    = ok_reg;
    assign out_sb    = sb_reg;

endmodule

// ----- rtl/look_at_view_matrix.sv -----
// Look-at view matrix: camera axes and translations from eye, target and up.
// Each item leaves as three rows on one output channel; input waits until row Z is taken.
// Each normalizer is a 32-stage square root plus a (AXIS_FRAC_BITS+1)-stage divider.
// The whole pipeline advances together; a stall on m_tready holds every stage.
// Reset: aresetn (sync, active low) clears all valid bits and the output; payload is not reset.
`timescale 1ns / 1ps

module look_at_view_matrix #(
    parameter int AXIS_FRAC_BITS = lav_pkg::AXIS_FRAC_BITS_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // eye_x, eye_y, eye_z, target_x, target_y, target_z, up_x, up_y, up_z (32 bits each)
    input  logic [9*lav_pkg::COORD_W-1:0] s_tdata,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // axis_x, axis_y, axis_z, translation, zero padding to whole bytes
    output logic [((3*(AXIS_FRAC_BITS+2)+lav_pkg::COORD_W+7)/8)*8-1:0] m_tdata,
    // row_index[1:0], degenerate[2]
    output logic [2:0]             m_tuser,
    output logic                   m_tlast
);

    localparam int CW = lav_pkg::COORD_W;
    localparam int VW = lav_pkg::VEC_W;
    localparam int AW = AXIS_FRAC_BITS + 2;
    localparam int DW = ((3 * AW + CW + 7) / 8) * 8;

    typedef logic [2:0][CW-1:0] cvec_t;
    typedef logic [2:0][AW-1:0] avec_t;
    typedef logic [2:0][VW-1:0] wvec_t;

    // sideband carried through each normalizer
    typedef struct packed {
        cvec_t up;
        cvec_t eye;
    } sb1_t;

    typedef struct packed {
        logic  ok;
        avec_t z;
        cvec_t eye;
    } sb2_t;

    typedef struct packed {
        logic  ok;
        avec_t x;
        avec_t z;
        cvec_t eye;
    } sb3_t;

    // global advance: every stage moves when the output stage can load
    logic en;
    lav_pkg::row_t row_reg;
    logic m_tvalid_reg;

    assign en       = !m_tvalid_reg || (m_tready && row_reg == lav_pkg::ROW_Z);
    assign s_tready = en;

    // ---------------- input stage: view direction eye - target ----------------
    logic  in_v_reg;
    sb1_t  in_sb_reg;
    wvec_t d_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_v_reg <= 1'b0;
        end else if (en) begin
            in_v_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                in_sb_reg.eye[i] <= s_tdata[CW*i +: CW];
                in_sb_reg.up[i]  <= s_tdata[CW*(6+i) +: CW];
                d_reg[i] <= {{(VW-CW){s_tdata[CW*i+CW-1]}}, s_tdata[CW*i +: CW]}
                          - {{(VW-CW){s_tdata[CW*(3+i)+CW-1]}}, s_tdata[CW*(3+i) +: CW]};
            end
        end
    end

    // ---------------- z axis ----------------
    logic  n1_v;
    avec_t n1_ax;
    logic  n1_ok;
    sb1_t  n1_sb;

    lav_norm #(
        .AXIS_FRAC_BITS (AXIS_FRAC_BITS),
        .SB_W           ($bits(sb1_t))
    ) u_norm_z (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (in_v_reg),
        .in_vec    (d_reg),
        .in_sb     (in_sb_reg),
        .out_valid (n1_v),
        .out_axis  (n1_ax),
        .out_ok    (n1_ok),
        .out_sb    (n1_sb)
    );

    // ---------------- cross(up, z): products, then differences ----------------
    logic  c1a_v_reg;
    wvec_t c1a_pa_reg, c1a_pb_reg;
    sb2_t  c1a_sb_reg;
    logic  c1b_v_reg;
    wvec_t c1b_vec_reg;
    sb2_t  c1b_sb_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c1a_v_reg <= 1'b0;
            c1b_v_reg <= 1'b0;
        end else if (en) begin
            c1a_v_reg <= n1_v;
            c1b_v_reg <= c1a_v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                c1a_pa_reg[i] <= $signed(n1_sb.up[(i+1)%3]) * $signed(n1_ax[(i+2)%3]);
                c1a_pb_reg[i] <= $signed(n1_sb.up[(i+2)%3]) * $signed(n1_ax[(i+1)%3]);
                c1b_vec_reg[i] <= c1a_pa_reg[i] - c1a_pb_reg[i];
            end
            c1a_sb_reg.ok  <= n1_ok;
            c1a_sb_reg.z   <= n1_ax;
            c1a_sb_reg.eye <= n1_sb.eye;
            c1b_sb_reg     <= c1a_sb_reg;
        end
    end

    // ---------------- x axis ----------------
    logic  n2_v;
    avec_t n2_ax;
    logic  n2_ok;
    sb2_t  n2_sb;

    lav_norm #(
        .AXIS_FRAC_BITS (AXIS_FRAC_BITS),
        .SB_W           ($bits(sb2_t))
    ) u_norm_x (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (c1b_v_reg),
        .in_vec    (c1b_vec_reg),
        .in_sb     (c1b_sb_reg),
        .out_valid (n2_v),
        .out_axis  (n2_ax),
        .out_ok    (n2_ok),
        .out_sb    (n2_sb)
    );

    // ---------------- cross(z, x) ----------------
    logic  c2a_v_reg;
    wvec_t c2a_pa_reg, c2a_pb_reg;
    sb3_t  c2a_sb_reg;
    logic  c2b_v_reg;
    wvec_t c2b_vec_reg;
    sb3_t  c2b_sb_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c2a_v_reg <= 1'b0;
            c2b_v_reg <= 1'b0;
        end else if (en) begin
            c2a_v_reg <= n2_v;
            c2b_v_reg <= c2a_v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                c2a_pa_reg[i] <= $signed(n2_sb.z[(i+1)%3]) * $signed(n2_ax[(i+2)%3]);
                c2a_pb_reg[i] <= $signed(n2_sb.z[(i+2)%3]) * $signed(n2_ax[(i+1)%3]);
                c2b_vec_reg[i] <= c2a_pa_reg[i] - c2a_pb_reg[i];
            end
            c2a_sb_reg.ok  <= n2_sb.ok & n2_ok;
            c2a_sb_reg.x   <= n2_ax;
            c2a_sb_reg.z   <= n2_sb.z;
            c2a_sb_reg.eye <= n2_sb.eye;
            c2b_sb_reg     <= c2a_sb_reg;
        end
    end

    // ---------------- y axis ----------------
    logic  n3_v;
    avec_t n3_ax;
    logic  n3_ok;
    sb3_t  n3_sb;

    lav_norm #(
        .AXIS_FRAC_BITS (AXIS_FRAC_BITS),
        .SB_W           ($bits(sb3_t))
    ) u_norm_y (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (c2b_v_reg),
        .in_vec    (c2b_vec_reg),
        .in_sb     (c2b_sb_reg),
        .out_valid (n3_v),
        .out_axis  (n3_ax),
        .out_ok    (n3_ok),
        .out_sb    (n3_sb)
    );

    // ---------------- translations: products, sums, round and saturate ----------------
    logic                   da_v_reg, db_v_reg, dc_v_reg;
    logic [2:0][2:0][VW-1:0] da_prod_reg;
    logic [2:0]             da_ax_dummy;
    avec_t                  da_ax_reg [3];
    avec_t                  db_ax_reg [3];
    avec_t                  dc_ax_reg [3];
    logic                   da_ok_reg, db_ok_reg, dc_ok_reg;
    wvec_t                  db_sum_reg;
    logic [2:0][CW-1:0]     dc_tr_reg;
    logic [2:0][CW-1:0]     tr_next;
    avec_t                  rows [3];

    assign rows[lav_pkg::ROW_X] = n3_sb.x;
    assign rows[lav_pkg::ROW_Y] = n3_ax;
    assign rows[lav_pkg::ROW_Z] = n3_sb.z;
    assign da_ax_dummy = '0;

    always_comb begin
        logic [VW-1:0] mag;
        logic [VW-1:0] mr;
        for (int r = 0; r < 3; r++) begin
            mag = db_sum_reg[r][VW-1] ? (VW'(0) - db_sum_reg[r]) : db_sum_reg[r];
            mr  = (mag + (VW'(1) << (AXIS_FRAC_BITS - 1))) >> AXIS_FRAC_BITS;
            if (db_sum_reg[r][VW-1]) begin
                // negative dot gives a positive translation
                tr_next[r] = (mr > VW'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF : mr[CW-1:0];
            end else begin
                tr_next[r] = (mr > VW'(32'h8000_0000)) ? 32'h8000_0000
                                                        : CW'(VW'(0) - mr);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            da_v_reg <= 1'b0;
            db_v_reg <= 1'b0;
            dc_v_reg <= 1'b0;
        end else if (en) begin
            da_v_reg <= n3_v;
            db_v_reg <= da_v_reg;
            dc_v_reg <= db_v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int r = 0; r < 3; r++) begin
                for (int i = 0; i < 3; i++) begin
                    da_prod_reg[r][i] <= $signed(n3_sb.eye[i]) * $signed(rows[r][i]);
                end
                da_ax_reg[r]  <= rows[r] | avec_t'(da_ax_dummy);
                db_sum_reg[r] <= da_prod_reg[r][0] + da_prod_reg[r][1] + da_prod_reg[r][2];
                db_ax_reg[r]  <= da_ax_reg[r];
                dc_ax_reg[r]  <= db_ax_reg[r];
            end
            da_ok_reg <= n3_sb.ok & n3_ok;
            db_ok_reg <= da_ok_reg;
            dc_ok_reg <= db_ok_reg;
            dc_tr_reg <= tr_next;
        end
    end

    // ---------------- output stage: one item out as three rows ----------------
    avec_t              out_ax_reg [3];
    logic [2:0][CW-1:0] out_tr_reg;
    logic               deg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
            row_reg      <= lav_pkg::ROW_X;
        end else if (en) begin
            m_tvalid_reg <= dc_v_reg;
            row_reg      <= lav_pkg::ROW_X;
        end else if (m_tvalid_reg && m_tready) begin
            case (row_reg)
                lav_pkg::ROW_X: row_reg <= lav_pkg::ROW_Y;
                lav_pkg::ROW_Y: row_reg <= lav_pkg::ROW_Z;
                default:        row_reg <= lav_pkg::ROW_X;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            // degenerate items carry zero axes and translations
            for (int r = 0; r < 3; r++) begin
                out_ax_reg[r] <= dc_ok_reg ? dc_ax_reg[r] : '0;
                out_tr_reg[r] <= dc_ok_reg ? dc_tr_reg[r] : '0;
            end
            deg_reg <= !dc_ok_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = DW'({out_tr_reg[row_reg], out_ax_reg[row_reg][2],
                          out_ax_reg[row_reg][1], out_ax_reg[row_reg][0]});
    assign m_tuser  = {deg_reg, row_reg};
    assign m_tlast  = (row_reg == lav_pkg::ROW_Z);

endmodule
